// File: sv/dcbad_pkg.sv
// Shared types, address constants and window helpers of the dual-processor bus address decoder.
package dcbad_pkg;

    typedef logic [4:0] target_t;

    localparam target_t T_BIOS7     = 5'd0;
    localparam target_t T_MAIN      = 5'd1;
    localparam target_t T_SHARED    = 5'd2;
    localparam target_t T_WORK      = 5'd3;
    localparam target_t T_BIOS9     = 5'd4;
    localparam target_t T_ITCM      = 5'd5;
    localparam target_t T_DTCM      = 5'd6;
    localparam target_t T_DMA       = 5'd7;
    localparam target_t T_TIMER     = 5'd8;
    localparam target_t T_IPC       = 5'd9;
    localparam target_t T_CART      = 5'd10;
    localparam target_t T_INTC      = 5'd11;
    localparam target_t T_SPICTL    = 5'd12;
    localparam target_t T_SPIDATA   = 5'd13;
    localparam target_t T_DISPSTAT  = 5'd14;
    localparam target_t T_KEYS      = 5'd15;
    localparam target_t T_VRAM      = 5'd16;
    localparam target_t T_ROMDATA   = 5'd17;
    localparam target_t T_LOCAL     = 5'd18;
    localparam target_t T_IGNORED   = 5'd19;
    localparam target_t T_UNHANDLED = 5'd20;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    localparam logic [1:0] ALLOC_ALL_ARM9 = 2'd0;
    localparam logic [1:0] ALLOC_LOW_HALF = 2'd1;
    localparam logic [1:0] ALLOC_HIGH_HALF = 2'd2;
    localparam logic [1:0] ALLOC_ALL_ARM7 = 2'd3;

    localparam logic [31:0] MAIN_BASE    = 32'h0200_0000;
    localparam logic [31:0] SHARED_BASE  = 32'h0300_0000;
    localparam logic [31:0] WORK_BASE    = 32'h0380_0000;
    localparam logic [31:0] WIN_8M       = 32'h0080_0000;
    localparam logic [31:0] WIN_16M      = 32'h0100_0000;
    localparam logic [31:0] IO_BASE      = 32'h0400_0000;
    localparam logic [31:0] DMA_BASE     = 32'h0400_00B0;
    localparam logic [31:0] TIMER_BASE   = 32'h0400_0100;
    localparam logic [31:0] IPC_BASE     = 32'h0400_0180;
    localparam logic [31:0] CART_BASE    = 32'h0400_01A0;
    localparam logic [31:0] INTC_BASE    = 32'h0400_0208;
    localparam logic [31:0] BANK_BASE    = 32'h0400_0240;
    localparam logic [31:0] BANK_LAST    = 32'h0400_0249;
    localparam logic [31:0] VRAM_BASE    = 32'h0680_0000;
    localparam logic [31:0] BIOS7_LEN    = 32'h0000_4000;
    localparam logic [31:0] DTCM_BASE    = 32'h0080_0000;
    localparam logic [31:0] DTCM_ALIAS   = 32'h0B00_0000;
    localparam logic [31:0] ITCM_BASE    = 32'h0100_0000;
    localparam logic [31:0] BIOS9_BASE   = 32'hFFFF_0000;
    localparam logic [31:0] ROMDATA_ADDR = 32'h0410_0010;

    localparam logic [31:0] MASK_MAIN  = 32'h003F_FFFF;
    localparam logic [31:0] MASK_WORK  = 32'h0000_FFFF;
    localparam logic [31:0] MASK_16K   = 32'h0000_3FFF;
    localparam logic [31:0] MASK_32K   = 32'h0000_7FFF;
    localparam logic [31:0] HIGH_BANK  = 32'h0000_4000;
    localparam logic [31:0] MASK_B9_H  = 32'h0000_0FFE;
    localparam logic [31:0] MASK_B9_W  = 32'h0000_0FFC;

    // Byte offset of the allocation register inside the bank-control range.
    localparam logic [3:0] ALLOC_SLOT = 4'd7;

    typedef struct packed {
        logic        processor;
        logic        mode;
        logic [1:0]  access_size;
        logic [31:0] address;
        logic [31:0] write_data;
    } access_t;

    typedef struct packed {
        target_t     target;
        logic [21:0] local_offset;
        logic [31:0] read_data;
        logic        halt_request;
    } result_t;

    typedef struct packed {
        logic        alloc_we;
        logic [1:0]  alloc_val;
        logic        byte_we;
        logic [3:0]  byte_idx;
        logic [7:0]  byte_val;
        logic        word_we;
        logic [31:0] word_val;
    } state_upd_t;

    function automatic logic in_win(input logic [31:0] a, input logic [31:0] base,
                                    input logic [31:0] len);
        return (a >= base) && ((a - base) < len);
    endfunction

    function automatic logic [21:0] win_off(input logic [31:0] a, input logic [31:0] base);
        return 22'(a - base);
    endfunction

    function automatic logic [21:0] mask_off(input logic [31:0] a, input logic [31:0] mask);
        return 22'(a & mask);
    endfunction

endpackage

// File: sv/dcbad_state.sv
// Configuration port, power-on flag, shared-RAM allocation and bank-control registers.
module dcbad_state
    import dcbad_pkg::*;
#(
    parameter int VRAM_BANKS = 9
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        upd_en,
    input  state_upd_t  upd,
    output logic [7:0]  power_on_flag,
    output logic [1:0]  alloc,
    output logic [31:0] banks_lo
);

    logic [7:0] flag_reg;
    logic [7:0] flag_next;
    logic [1:0] alloc_reg;
    logic [1:0] alloc_next;
    logic [7:0] bank_reg [VRAM_BANKS];
    logic       cfg_wr;

    assign pready = 1'b1;
    // Only the first register exists; paddr[2] set is beyond the register list.
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {24'd0, flag_reg};

    assign flag_next  = cfg_wr ? pwdata[7:0] : flag_reg;
    assign alloc_next = (upd_en && upd.alloc_we) ? upd.alloc_val : alloc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg  <= 8'd0;
            alloc_reg <= ALLOC_ALL_ARM9;
        end else begin
            flag_reg  <= flag_next;
            alloc_reg <= alloc_next;
        end
    end

    for (genvar i = 0; i < VRAM_BANKS; i++) begin : g_bank
        logic [7:0] bank_next;
        always_comb begin
            bank_next = bank_reg[i];
            if (upd_en && upd.byte_we && upd.byte_idx == 4'(i)) begin
                bank_next = upd.byte_val;
            end
            if (i < 4) begin
                if (upd_en && upd.word_we) begin
                    bank_next = upd.word_val[8*(i%4) +: 8];
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                bank_reg[i] <= 8'd0;
            end else begin
                bank_reg[i] <= bank_next;
            end
        end
    end

    // Banks that do not exist read as zero.
    for (genvar j = 0; j < 4; j++) begin : g_lo
        if (j < VRAM_BANKS) begin : g_have
            assign banks_lo[8*j +: 8] = bank_reg[j];
        end else begin : g_none
            assign banks_lo[8*j +: 8] = 8'd0;
        end
    end

    assign power_on_flag = flag_reg;
    assign alloc         = alloc_reg;

endmodule

// File: sv/dcbad_decode.sv
// Region decode of one bus access into target, offset, local read data and state updates.
module dcbad_decode
    import dcbad_pkg::*;
(
    input  access_t     acc,
    input  logic [7:0]  power_on_flag,
    input  logic [1:0]  alloc,
    input  logic [31:0] banks_lo,
    output result_t     res,
    output state_upd_t  upd
);

    logic        wr;
    logic [1:0]  sz;
    logic [31:0] a;
    logic [31:0] d;
    logic [3:0]  kidx;
    logic [31:0] main_len;

    assign wr       = acc.mode;
    assign sz       = acc.access_size;
    assign a        = acc.address;
    assign d        = acc.write_data;
    assign kidx     = 4'(a - BANK_BASE);
    assign main_len = (sz == SZ_BYTE && !wr) ? WIN_8M : WIN_16M;

    always_comb begin
        res        = '0;
        res.target = T_UNHANDLED;
        upd        = '0;
        if (sz == 2'd3) begin
            res.target = T_UNHANDLED;
        end else if (!acc.processor) begin
            // ARM7 side
            if (a < BIOS7_LEN && !(wr && sz == SZ_HALF)) begin
                if (wr) begin
                    res.target = T_IGNORED;
                end else begin
                    res.target       = T_BIOS7;
                    res.local_offset = mask_off(a, MASK_16K);
                end
            end else if (in_win(a, MAIN_BASE, WIN_8M)) begin
                res.target       = T_MAIN;
                res.local_offset = mask_off(a, MASK_MAIN);
            end else if (in_win(a, SHARED_BASE, WIN_8M)) begin
                case (alloc)
                    ALLOC_ALL_ARM9: begin
                        res.target       = T_WORK;
                        res.local_offset = mask_off(a, MASK_WORK);
                    end
                    ALLOC_LOW_HALF: begin
                        res.target       = T_SHARED;
                        res.local_offset = mask_off(a, MASK_16K);
                    end
                    ALLOC_HIGH_HALF: begin
                        res.target       = T_SHARED;
                        res.local_offset = mask_off(HIGH_BANK | a, HIGH_BANK | MASK_16K);
                    end
                    default: begin
                        res.target       = T_SHARED;
                        res.local_offset = mask_off(a, MASK_32K);
                    end
                endcase
            end else if (in_win(a, WORK_BASE, WIN_8M)) begin
                res.target       = T_WORK;
                res.local_offset = mask_off(a, MASK_WORK);
            end else if (sz == SZ_HALF && in_win(a, DMA_BASE, 32'h30)) begin
                res.target       = T_DMA;
                res.local_offset = win_off(a, DMA_BASE);
            end else if (wr && sz != SZ_BYTE && in_win(a, TIMER_BASE, 32'h10)) begin
                res.target       = T_TIMER;
                res.local_offset = win_off(a, TIMER_BASE);
            end else if ((wr || sz == SZ_WORD) && in_win(a, CART_BASE, 32'h1C)) begin
                res.target       = T_CART;
                res.local_offset = win_off(a, CART_BASE);
            end else if (sz == SZ_HALF && in_win(a, IPC_BASE, 32'h10)) begin
                res.target       = T_IPC;
                res.local_offset = win_off(a, IPC_BASE);
            end else if ((wr || sz == SZ_WORD) && in_win(a, INTC_BASE, 32'h10)) begin
                res.target       = T_INTC;
                res.local_offset = win_off(a, INTC_BASE);
            end else if (sz == SZ_BYTE) begin
                if (a == IO_BASE + 32'h138) begin
                    res.target = wr ? T_IGNORED : T_LOCAL;
                end else if (a == IO_BASE + 32'h1C2) begin
                    res.target = T_SPIDATA;
                end else if (!wr && a == IO_BASE + 32'h300) begin
                    res.target    = T_LOCAL;
                    res.read_data = {24'd0, power_on_flag};
                end else if (wr && a == IO_BASE + 32'h301) begin
                    res.target       = T_LOCAL;
                    res.halt_request = d[7];
                end
            end else if (sz == SZ_HALF) begin
                if (!wr && a == IO_BASE + 32'h4) begin
                    res.target = T_DISPSTAT;
                end else if (!wr && a == IO_BASE + 32'h130) begin
                    res.target = T_KEYS;
                end else if (wr && a == IO_BASE + 32'h1C0) begin
                    res.target = T_SPICTL;
                end else if (wr && a == IO_BASE + 32'h1C2) begin
                    res.target = T_SPIDATA;
                end
            end else if (!wr) begin
                if (a == IO_BASE + 32'h1C0) begin
                    res.target = T_SPICTL;
                end else if (a == ROMDATA_ADDR) begin
                    res.target = T_ROMDATA;
                end
            end
        end else begin
            // ARM9 side
            if (sz == SZ_WORD && in_win(a, DTCM_BASE, 32'h4000)) begin
                res.target       = T_DTCM;
                res.local_offset = mask_off(a, MASK_16K);
            end else if (sz == SZ_WORD && in_win(a, ITCM_BASE, 32'h8000)) begin
                res.target       = T_ITCM;
                res.local_offset = mask_off(a, MASK_32K);
            end else if (in_win(a, MAIN_BASE, main_len)) begin
                res.target       = T_MAIN;
                res.local_offset = mask_off(a, MASK_MAIN);
            end else if (sz != SZ_BYTE && in_win(a, IO_BASE, 32'h70)) begin
                // Word reads of this range have no handler anywhere further down.
                if (sz == SZ_HALF && a == IO_BASE + 32'h4) begin
                    res.target = T_DISPSTAT;
                end else if (sz == SZ_WORD && !wr) begin
                    res.target = T_UNHANDLED;
                end else begin
                    res.target = wr ? T_IGNORED : T_LOCAL;
                end
            end else if (sz == SZ_WORD && in_win(a, DMA_BASE, 32'h40)) begin
                res.target       = T_DMA;
                res.local_offset = win_off(a, DMA_BASE);
            end else if (wr && sz == SZ_HALF && in_win(a, DMA_BASE, 32'h30)) begin
                res.target       = T_DMA;
                res.local_offset = win_off(a, DMA_BASE);
            end else if (wr && sz == SZ_HALF && in_win(a, TIMER_BASE, 32'h10)) begin
                res.target       = T_TIMER;
                res.local_offset = win_off(a, TIMER_BASE);
            end else if (sz == SZ_HALF && in_win(a, IPC_BASE, 32'h10)) begin
                res.target       = T_IPC;
                res.local_offset = win_off(a, IPC_BASE);
            end else if (in_win(a, INTC_BASE, 32'h10)) begin
                res.target       = T_INTC;
                res.local_offset = win_off(a, INTC_BASE);
            end else if (wr && sz == SZ_WORD && (in_win(a, 32'h0400_1000, 32'h70)
                         || in_win(a, 32'h0500_0000, 32'h800))) begin
                res.target = T_IGNORED;
            end else if (wr && sz != SZ_BYTE && in_win(a, VRAM_BASE, 32'h000A_4000)) begin
                res.target       = T_VRAM;
                res.local_offset = win_off(a, VRAM_BASE);
            end else if (wr && sz == SZ_WORD && in_win(a, 32'h0700_0000, 32'h800)) begin
                res.target = T_IGNORED;
            end else if (sz == SZ_WORD && in_win(a, DTCM_ALIAS, 32'h4000)) begin
                res.target       = T_DTCM;
                res.local_offset = mask_off(a, MASK_16K);
            end else if (!wr && sz != SZ_BYTE && a >= BIOS9_BASE) begin
                res.target       = T_BIOS9;
                res.local_offset = mask_off(a, (sz == SZ_HALF) ? MASK_B9_H : MASK_B9_W);
            end else if (sz == SZ_BYTE) begin
                if (!wr && a == IO_BASE + 32'h300) begin
                    res.target    = T_LOCAL;
                    res.read_data = {24'd0, power_on_flag};
                end else if (wr && a inside {[BANK_BASE : BANK_LAST]}) begin
                    res.target = T_LOCAL;
                    if (kidx == ALLOC_SLOT) begin
                        upd.alloc_we  = 1'b1;
                        upd.alloc_val = d[1:0];
                    end else begin
                        // Bank controls skip the allocation byte.
                        upd.byte_we  = 1'b1;
                        upd.byte_idx = (kidx < ALLOC_SLOT) ? kidx : kidx - 4'd1;
                        upd.byte_val = d[7:0];
                    end
                end
            end else if (sz == SZ_HALF) begin
                if (!wr && a == IO_BASE + 32'h130) begin
                    res.target = T_KEYS;
                end else if (wr && (a == IO_BASE + 32'h204 || a == IO_BASE + 32'h304)) begin
                    res.target = T_IGNORED;
                end
            end else if (!wr) begin
                if (a == BANK_BASE) begin
                    res.target    = T_LOCAL;
                    res.read_data = banks_lo;
                end else if (a == IO_BASE + 32'h4000 || a == IO_BASE + 32'h4008) begin
                    res.target = T_LOCAL;
                end
            end else begin
                if (a == IO_BASE + 32'h1A0 || a == IO_BASE + 32'h1A4
                    || a == IO_BASE + 32'h304) begin
                    res.target = T_IGNORED;
                end else if (a == BANK_BASE) begin
                    res.target    = T_LOCAL;
                    upd.word_we   = 1'b1;
                    upd.word_val  = d;
                end
            end
        end
    end

endmodule

// File: sv/dual_cpu_bus_address_decoder_unit.sv
// Top level of the dual-processor bus address decoder: stream stages around the decode.
// An accepted access beat waits in the input register; its decoded result is then
// presented from the result register. Throughput: one access beat per cycle unless
// m_tready stalls; a new beat can enter while a finished result waits on m_tready.
// Reset clears both stage valids, the power-on flag, the shared-RAM allocation
// and all bank-control bytes to zero.
module dual_cpu_bus_address_decoder_unit
    import dcbad_pkg::*;
#(
    parameter int VRAM_BANKS = 9
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // address [31:0], write_data [63:32]
    input  logic [3:0]  s_tuser,   // processor [0], mode [1], access_size [3:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // local_offset [21:0], read_data [53:22],
                                   // halt_request [54], zero [55]
    output logic [4:0]  m_tuser,   // target [4:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        in_valid_reg;
    logic        in_valid_next;
    access_t     in_acc_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     res_reg;
    result_t     res_comb;
    state_upd_t  upd;
    logic        advance;
    logic        s_fire;
    logic [7:0]  power_on_flag;
    logic [1:0]  alloc;
    logic [31:0] banks_lo;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    assign in_valid_next  = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_acc_reg.processor   <= s_tuser[0];
            in_acc_reg.mode        <= s_tuser[1];
            in_acc_reg.access_size <= s_tuser[3:2];
            in_acc_reg.address     <= s_tdata[31:0];
            in_acc_reg.write_data  <= s_tdata[63:32];
        end
        if (advance) begin
            res_reg <= res_comb;
        end
    end

    dcbad_decode u_decode (
        .acc           (in_acc_reg),
        .power_on_flag (power_on_flag),
        .alloc         (alloc),
        .banks_lo      (banks_lo),
        .res           (res_comb),
        .upd           (upd)
    );

    // State changes take effect as the access leaves the input register, so the
    // next access already decodes against them.
    dcbad_state #(
        .VRAM_BANKS (VRAM_BANKS)
    ) u_state (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .upd_en        (advance),
        .upd           (upd),
        .power_on_flag (power_on_flag),
        .alloc         (alloc),
        .banks_lo      (banks_lo)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, res_reg.halt_request, res_reg.read_data, res_reg.local_offset};
    assign m_tuser  = res_reg.target;

    a_halt_local: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[54] |-> m_tuser == T_LOCAL)
        else $error("halt request on a beat whose target is not local");

    a_data_local: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[53:22] != 32'd0 |-> m_tuser == T_LOCAL)
        else $error("nonzero read data on a beat whose target is not local");

    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("held access did not move into a free result register");

    a_upd_arm9: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (upd.alloc_we || upd.byte_we || upd.word_we)
        |-> in_acc_reg.processor && in_acc_reg.mode)
        else $error("bank-control update from an access that is not an ARM9 write");

endmodule
